// ===== rtl/pps_pkg.sv =====
// package for the perspective point to screen block
// payload structs, register indexes and fixed widths; no dependencies
package pps_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int IN_W   = 20;
  localparam int SCR_W  = 14;
  localparam int PROJ_W = 19;
  localparam int OUT_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int QUOT_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_PROJ_SIZE     = 2'd2,
    REG_PROJ_DIST     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] point_x;
    logic signed [IN_W-1:0] point_y;
    logic signed [IN_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic                    in_front;
    logic                    saturated;
  } pixel_t;

  typedef struct packed {
    logic [SCR_W-1:0]  screen_width;
    logic [SCR_W-1:0]  screen_height;
    logic [PROJ_W-1:0] proj_size;
    logic [PROJ_W-1:0] proj_dist;
  } cfg_t;

endpackage

// ===== rtl/pps_front.sv =====
// front end: depth, products and the two numerators with the common denominator
// depends on pps_pkg
module pps_front
  import pps_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DEN_W = 39,
  parameter int NW = 56
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  point_t               in_data,
  input  cfg_t                 cfg,
  output logic                 valid,
  output logic                 front,
  output logic signed [NW-1:0] num_x,
  output logic signed [NW-1:0] num_y,
  output logic [DEN_W-1:0]     den
);

  localparam int DW  = (COORD_FRAC_BITS > PROJ_W ? COORD_FRAC_BITS : PROJ_W) + 2;
  localparam int PW  = IN_W + PROJ_W + 1;
  localparam int MW  = PW + SCR_W + 1;
  localparam int HW  = SCR_W - 1;

  logic signed [DW-1:0] d;
  logic [DW-2:0] d_pos;
  logic [SCR_W-1:0] m;

  // stage 1
  logic v1_r, f1_r;
  logic signed [PW-1:0] xp1_r, yp1_r;
  logic [DEN_W-1:0] den1_r;
  // stage 2
  logic v2_r, f2_r;
  logic signed [MW-1:0] mx2_r, my2_r;
  logic [DEN_W+HW-1:0] hwd2_r, hhd2_r;
  logic [DEN_W-1:0] den2_r;
  // stage 3
  logic v3_r, f3_r;
  logic signed [NW-1:0] nx3_r, ny3_r;
  logic [DEN_W-1:0] den3_r;

  always_comb begin
    d     = (DW'(1) <<< COORD_FRAC_BITS) - DW'(in_data.point_z);
    d_pos = (d > 0) ? d[DW-2:0] : '0;
    m     = (cfg.screen_width < cfg.screen_height) ? cfg.screen_width : cfg.screen_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= (d > 0);
      xp1_r  <= PW'(in_data.point_x) * PW'($signed({1'b0, cfg.proj_dist}));
      yp1_r  <= -(PW'(in_data.point_y) * PW'($signed({1'b0, cfg.proj_dist})));
      den1_r <= DEN_W'(d_pos) * DEN_W'(cfg.proj_size == '0 ? PROJ_W'(1) : cfg.proj_size);

      f2_r   <= f1_r;
      mx2_r  <= MW'(xp1_r) * MW'($signed({1'b0, m}));
      my2_r  <= MW'(yp1_r) * MW'($signed({1'b0, m}));
      hwd2_r <= (DEN_W+HW)'(cfg.screen_width[SCR_W-1:1]) * (DEN_W+HW)'(den1_r);
      hhd2_r <= (DEN_W+HW)'(cfg.screen_height[SCR_W-1:1]) * (DEN_W+HW)'(den1_r);
      den2_r <= den1_r;

      f3_r   <= f2_r;
      nx3_r  <= NW'(mx2_r) + NW'($signed({1'b0, hwd2_r}));
      ny3_r  <= NW'(my2_r) + NW'($signed({1'b0, hhd2_r}));
      den3_r <= den2_r;
    end
  end

  assign valid = v3_r;
  assign front = f3_r;
  assign num_x = nx3_r;
  assign num_y = ny3_r;
  assign den   = den3_r;

endmodule

// ===== rtl/pps_div.sv =====
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a denominator
// depends on pps_pkg
module pps_div
  import pps_pkg::*;
#(
  parameter int DEN_W = 39,
  parameter int NW = 56
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_front,
  input  logic signed [NW-1:0] num_x,
  input  logic signed [NW-1:0] num_y,
  input  logic [DEN_W-1:0]     den,
  output logic                 valid,
  output logic                 front,
  output logic [QUOT_W-1:0]    quot_x,
  output logic [QUOT_W-1:0]    quot_y,
  output logic                 neg_x,
  output logic                 neg_y,
  output logic                 ovf_x,
  output logic                 ovf_y
);

  localparam int RW = ((NW > DEN_W + QUOT_W) ? NW : DEN_W + QUOT_W) + 1;

  // absolute value stage
  logic a_v_r, a_f_r, a_nx_r, a_ny_r;
  logic [RW-1:0] a_mx_r, a_my_r;
  logic [DEN_W-1:0] a_den_r;

  // bit stages, entry 0 is the overflow check stage
  logic              v_r   [QUOT_W+1];
  logic              f_r   [QUOT_W+1];
  logic              nx_r  [QUOT_W+1];
  logic              ny_r  [QUOT_W+1];
  logic              ox_r  [QUOT_W+1];
  logic              oy_r  [QUOT_W+1];
  logic [RW-1:0]     rx_r  [QUOT_W+1];
  logic [RW-1:0]     ry_r  [QUOT_W+1];
  logic [QUOT_W-1:0] qx_r  [QUOT_W+1];
  logic [QUOT_W-1:0] qy_r  [QUOT_W+1];
  logic [DEN_W-1:0]  dn_r  [QUOT_W+1];

  logic [RW-1:0]     rx_nxt [QUOT_W];
  logic [RW-1:0]     ry_nxt [QUOT_W];
  logic [QUOT_W-1:0] qx_nxt [QUOT_W];
  logic [QUOT_W-1:0] qy_nxt [QUOT_W];

  always_comb begin
    logic [RW-1:0] sh;
    for (int i = 0; i < QUOT_W; i++) begin
      sh = RW'(dn_r[i]) << (QUOT_W - 1 - i);
      rx_nxt[i] = rx_r[i];
      qx_nxt[i] = qx_r[i];
      ry_nxt[i] = ry_r[i];
      qy_nxt[i] = qy_r[i];
      if (rx_r[i] >= sh) begin
        rx_nxt[i] = rx_r[i] - sh;
        qx_nxt[i][QUOT_W-1-i] = 1'b1;
      end
      if (ry_r[i] >= sh) begin
        ry_nxt[i] = ry_r[i] - sh;
        qy_nxt[i][QUOT_W-1-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      for (int i = 0; i <= QUOT_W; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      a_v_r  <= in_valid;
      v_r[0] <= a_v_r;
      for (int i = 0; i < QUOT_W; i++) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f_r   <= in_front;
      a_nx_r  <= num_x[NW-1];
      a_ny_r  <= num_y[NW-1];
      a_mx_r  <= num_x[NW-1] ? RW'(-num_x) : RW'(num_x);
      a_my_r  <= num_y[NW-1] ? RW'(-num_y) : RW'(num_y);
      a_den_r <= den;

      f_r[0]  <= a_f_r;
      nx_r[0] <= a_nx_r;
      ny_r[0] <= a_ny_r;
      ox_r[0] <= a_mx_r >= (RW'(a_den_r) << QUOT_W);
      oy_r[0] <= a_my_r >= (RW'(a_den_r) << QUOT_W);
      rx_r[0] <= a_mx_r;
      ry_r[0] <= a_my_r;
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      dn_r[0] <= a_den_r;

      for (int i = 0; i < QUOT_W; i++) begin
        f_r[i+1]  <= f_r[i];
        nx_r[i+1] <= nx_r[i];
        ny_r[i+1] <= ny_r[i];
        ox_r[i+1] <= ox_r[i];
        oy_r[i+1] <= oy_r[i];
        rx_r[i+1] <= rx_nxt[i];
        ry_r[i+1] <= ry_nxt[i];
        qx_r[i+1] <= qx_nxt[i];
        qy_r[i+1] <= qy_nxt[i];
        dn_r[i+1] <= dn_r[i];
      end
    end
  end

  assign valid  = v_r[QUOT_W];
  assign front  = f_r[QUOT_W];
  assign quot_x = qx_r[QUOT_W];
  assign quot_y = qy_r[QUOT_W];
  assign neg_x  = nx_r[QUOT_W];
  assign neg_y  = ny_r[QUOT_W];
  assign ovf_x  = ox_r[QUOT_W];
  assign ovf_y  = oy_r[QUOT_W];

endmodule

// ===== rtl/perspective_point_to_screen.sv =====
// top level of the perspective point to screen block
// holds the configuration registers, the front end, the divider and the output clamp
// depends on pps_pkg, pps_front and pps_div
//
// input beats carry one point (x, y, z in signed fixed point); each gives exactly one
// output beat with the pixel coordinates, an in-front flag and a saturation flag.
// a beat is taken on a rising edge where valid is high and stall is low.
// the pipeline has three front end stages, an absolute value stage, an
// overflow check stage, 17 quotient bit stages and the clamp register.
// throughput is one point per cycle when not stalled; the divider resolves one
// quotient bit per stage. when out_stall is high while a result is shown, the
// whole pipeline holds and in_stall rises; nothing is dropped or repeated.
// configuration writes are always ready and must only happen while the pipeline is empty.
// synchronous reset empties the pipeline and restores 640 by 480 with unit plane
// size and distance.
module perspective_point_to_screen
  import pps_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  point_t               in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pixel_t               out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PROJ_W-1:0]    cfg_data
);

  localparam int DW    = (COORD_FRAC_BITS > PROJ_W ? COORD_FRAC_BITS : PROJ_W) + 2;
  localparam int DEN_W = DW - 1 + PROJ_W;
  localparam int MW    = IN_W + PROJ_W + 1 + SCR_W + 1;
  localparam int NW    = ((MW > DEN_W + SCR_W) ? MW : DEN_W + SCR_W) + 1;
  localparam logic [QUOT_W-1:0] POS_MAX = QUOT_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [QUOT_W-1:0] NEG_MAX = QUOT_W'(1 << (OUT_W - 1));

  cfg_t cfg_r;
  logic en;
  logic f_valid, f_front;
  logic signed [NW-1:0] f_nx, f_ny;
  logic [DEN_W-1:0] f_den;
  logic d_valid, d_front, d_negx, d_negy, d_ovx, d_ovy;
  logic [QUOT_W-1:0] d_qx, d_qy;
  logic out_valid_r;
  pixel_t out_r, out_nxt;
  logic sat_x, sat_y;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= SCR_W'(640);
      cfg_r.screen_height <= SCR_W'(480);
      cfg_r.proj_size     <= PROJ_W'(65536);
      cfg_r.proj_dist     <= PROJ_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data[SCR_W-1:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data[SCR_W-1:0];
        REG_PROJ_SIZE:     cfg_r.proj_size     <= cfg_data;
        REG_PROJ_DIST:     cfg_r.proj_dist     <= cfg_data;
        default: ;
      endcase
    end
  end

  pps_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .DEN_W(DEN_W),
    .NW(NW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .in_valid(in_valid),
    .in_data(in_data),
    .cfg(cfg_r),
    .valid(f_valid),
    .front(f_front),
    .num_x(f_nx),
    .num_y(f_ny),
    .den(f_den)
  );

  pps_div #(
    .DEN_W(DEN_W),
    .NW(NW)
  ) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .in_valid(f_valid),
    .in_front(f_front),
    .num_x(f_nx),
    .num_y(f_ny),
    .den(f_den),
    .valid(d_valid),
    .front(d_front),
    .quot_x(d_qx),
    .quot_y(d_qy),
    .neg_x(d_negx),
    .neg_y(d_negy),
    .ovf_x(d_ovx),
    .ovf_y(d_ovy)
  );

  always_comb begin
    sat_x = 1'b0;
    sat_y = 1'b0;
    out_nxt = '0;
    if (d_negx) begin
      if (d_ovx || d_qx > NEG_MAX) begin
        sat_x = 1'b1;
        out_nxt.screen_x = OUT_W'(NEG_MAX);
      end else begin
        out_nxt.screen_x = OUT_W'(-d_qx);
      end
    end else begin
      if (d_ovx || d_qx > POS_MAX) begin
        sat_x = 1'b1;
        out_nxt.screen_x = OUT_W'(POS_MAX);
      end else begin
        out_nxt.screen_x = OUT_W'(d_qx);
      end
    end
    if (d_negy) begin
      if (d_ovy || d_qy > NEG_MAX) begin
        sat_y = 1'b1;
        out_nxt.screen_y = OUT_W'(NEG_MAX);
      end else begin
        out_nxt.screen_y = OUT_W'(-d_qy);
      end
    end else begin
      if (d_ovy || d_qy > POS_MAX) begin
        sat_y = 1'b1;
        out_nxt.screen_y = OUT_W'(POS_MAX);
      end else begin
        out_nxt.screen_y = OUT_W'(d_qy);
      end
    end
    out_nxt.in_front  = d_front;
    out_nxt.saturated = sat_x || sat_y;
    if (!d_front) begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
